// ===== rtl/core/k_combination_enumerator_defines.svh =====
// -----------------------------------------------------------------------------
// k_combination_enumerator_defines.svh
// Assertion macros for the top file of the combination enumerator.
// -----------------------------------------------------------------------------
`ifndef K_COMBINATION_ENUMERATOR_DEFINES_SVH
`define K_COMBINATION_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/kce_pkg.sv =====
// -----------------------------------------------------------------------------
// kce_pkg
// Types and codes shared by the modules of the combination enumerator.
// -----------------------------------------------------------------------------
package kce_pkg;

	// Fixed field widths.
	localparam int CMD_W   = 2;
	localparam int ENTRY_W = 4;
	localparam int ELEM_W  = 32;
	localparam int CFG_W   = 5;
	localparam int REG_W   = 2;
	localparam int STAT_W  = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_STARTED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED   = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_SET_SIZE    = 2'd0;
	localparam logic [REG_W-1:0] REG_SUBSET_SIZE = 2'd1;
	localparam logic [REG_W-1:0] REG_OUTPUT_MODE = 2'd2;

	// Output mode codes.
	localparam logic MODE_INDEX = 1'b0;
	localparam logic MODE_VALUE = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FILL,
		ST_EMIT_RD,
		ST_EMIT_ADDR,
		ST_EMIT_LOAD,
		ST_WAIT
	} kce_state_t;

	// Result word request from the sequencer to the output register.
	typedef struct packed {
		logic              load;
		logic [STAT_W-1:0] status;
		logic              last;
		logic              more;
	} kce_out_t;

endpackage

// ===== rtl/core/kce_ram.sv =====
// -----------------------------------------------------------------------------
// kce_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module kce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/kce_cmp.sv =====
// -----------------------------------------------------------------------------
// kce_cmp
// Shared limit compare: tells whether a position can still be advanced.
// -----------------------------------------------------------------------------
module kce_cmp #(
	parameter int NW = 5,
	parameter int PW = 4
) (
	input  logic [NW-1:0] n_eff,
	input  logic [NW-1:0] k_eff,
	input  logic [PW-1:0] idx,
	input  logic [PW-1:0] pos,
	output logic          below
);

	logic [NW-1:0] limit;

	// Position i may still move while it lies below n - k + i.
	assign limit = (n_eff - k_eff) + NW'(idx);
	assign below = NW'(pos) < limit;

endmodule

// ===== rtl/core/kce_ctrl.sv =====
// -----------------------------------------------------------------------------
// kce_ctrl
// Sequencer that scans, advances and emits the position table one entry at a time.
// -----------------------------------------------------------------------------
module kce_ctrl
	import kce_pkg::*;
#(
	parameter int MAX_SET = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_valid,
	input  logic [CMD_W-1:0]              cmd,
	output logic                          ready,
	input  logic [$clog2(MAX_SET+1)-1:0]  n_eff,
	input  logic [$clog2(MAX_SET+1)-1:0]  k_eff,
	input  logic [$clog2(MAX_SET)-1:0]    pos_rdata,
	output logic                          pos_we,
	output logic [$clog2(MAX_SET)-1:0]    pos_addr,
	output logic [$clog2(MAX_SET)-1:0]    pos_wdata,
	output logic [$clog2(MAX_SET)-1:0]    elem_pos,
	input  logic                          out_taken,
	output kce_out_t                      out_req
);

	localparam int PW = $clog2(MAX_SET);
	localparam int NW = $clog2(MAX_SET + 1);

	kce_state_t    state_q, state_d;
	logic [PW-1:0] idx_q;
	logic [NW-1:0] val_q;
	logic [PW-1:0] elem_pos_q;
	logic          started_q, first_q, exhausted_q;
	logic          more_q, scan_more_q;

	logic          accept;
	logic          below;
	logic          idx_zero;
	logic          fill_done;
	logic [PW-1:0] idx_top;

	assign accept    = s_valid && ready;
	assign idx_zero  = (idx_q == '0);
	assign idx_top   = PW'(k_eff - NW'(1));
	assign fill_done = (idx_q == idx_top);

	// Shared compare unit used by both the pivot scan and the lookahead scan.
	kce_cmp #(
		.NW (NW),
		.PW (PW)
	) u_cmp (
		.n_eff (n_eff),
		.k_eff (k_eff),
		.idx   (idx_q),
		.pos   (pos_rdata),
		.below (below)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_RESTART: state_d = ST_INIT;
						CMD_NEXT: begin
							state_d = (!started_q || exhausted_q) ? ST_WAIT : ST_SCAN_RD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				if (idx_q == PW'(MAX_SET - 1)) state_d = ST_IDLE;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (below) begin
					state_d = scan_more_q ? ST_EMIT_RD : ST_FILL;
				end else if (idx_zero) begin
					state_d = scan_more_q ? ST_EMIT_RD : ST_WAIT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_FILL: begin
				if (fill_done) state_d = ST_SCAN_RD;
			end
			ST_EMIT_RD:   state_d = ST_EMIT_ADDR;
			ST_EMIT_ADDR: state_d = ST_EMIT_LOAD;
			ST_EMIT_LOAD: state_d = ST_WAIT;
			ST_WAIT: begin
				if (out_taken) state_d = idx_zero ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: position table access and result word requests.
	always_comb begin
		ready          = (state_q == ST_IDLE);
		pos_addr       = idx_q;
		pos_we         = 1'b0;
		pos_wdata      = idx_q;
		out_req.load   = 1'b0;
		out_req.status = STAT_OK;
		out_req.last   = 1'b1;
		out_req.more   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_NEXT && (!started_q || exhausted_q)) begin
					out_req.load   = 1'b1;
					out_req.status = started_q ? STAT_EXHAUSTED : STAT_NOT_STARTED;
				end
			end
			ST_INIT: pos_we = 1'b1;
			ST_FILL: begin
				pos_we    = 1'b1;
				pos_wdata = val_q[PW-1:0];
			end
			ST_SCAN_CHK: begin
				if (!below && idx_zero && !scan_more_q) begin
					out_req.load   = 1'b1;
					out_req.status = STAT_EXHAUSTED;
				end
			end
			ST_EMIT_LOAD: begin
				out_req.load = 1'b1;
				out_req.last = idx_zero;
				out_req.more = more_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			started_q   <= 1'b0;
			first_q     <= 1'b0;
			exhausted_q <= 1'b0;
			more_q      <= 1'b0;
			scan_more_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_RESTART) begin
						idx_q       <= '0;
						started_q   <= 1'b1;
						first_q     <= 1'b1;
						exhausted_q <= 1'b0;
					end else if (accept && cmd == CMD_NEXT) begin
						if (!started_q || exhausted_q) begin
							idx_q <= '0;
						end else begin
							// The first combination after a restart skips the advance.
							idx_q       <= idx_top;
							scan_more_q <= first_q;
							first_q     <= 1'b0;
						end
					end
				end
				ST_INIT: idx_q <= idx_q + PW'(1);
				ST_SCAN_CHK: begin
					if (below) begin
						if (scan_more_q) begin
							more_q <= 1'b1;
							idx_q  <= idx_top;
						end
					end else if (idx_zero) begin
						exhausted_q <= 1'b1;
						if (scan_more_q) begin
							more_q <= 1'b0;
							idx_q  <= idx_top;
						end
					end else begin
						idx_q <= idx_q - PW'(1);
					end
				end
				ST_FILL: begin
					if (fill_done) begin
						idx_q       <= idx_top;
						scan_more_q <= 1'b1;
					end else begin
						idx_q <= idx_q + PW'(1);
					end
				end
				ST_WAIT: begin
					if (out_taken && !idx_zero) idx_q <= idx_q - PW'(1);
				end
				default: ;
			endcase
		end
	end

	// Working values: the running fill value and the position being emitted.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN_CHK && below && !scan_more_q) begin
			val_q <= NW'(pos_rdata) + NW'(1);
		end else if (state_q == ST_FILL) begin
			val_q <= val_q + NW'(1);
		end
		if (state_q == ST_EMIT_ADDR) begin
			elem_pos_q <= pos_rdata;
		end
	end

	assign elem_pos = elem_pos_q;

endmodule

// ===== rtl/core/k_combination_enumerator.sv =====
// -----------------------------------------------------------------------------
// k_combination_enumerator
// Lexicographic k-combination successor over a loadable table of signed values.
// -----------------------------------------------------------------------------
// Channel  Dir  Handshake           Contents
// s_       in   s_tvalid/s_tready   tuser command; tdata entry_index, entry_value
// m_       out  m_tvalid/m_tready   tdata element; tlast last_of_run;
//                                   tuser more_follow, status
// cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A load is written straight into the set table; a restart refills the position table with 0..MAX_SET-1.
// A next scans the positions down for the pivot, rewrites the positions from the pivot up, then
// scans again (lookahead) and emits one word per element, paced by the single position-table port
// and the shared compare; a next with nothing left to enumerate is answered with a status word.
// The input is ready only while the sequencer is idle; a stalled output word holds the block.
// Reset clears the control state and loads the register defaults; the tables are not cleared.
// -----------------------------------------------------------------------------
module k_combination_enumerator
	import kce_pkg::*;
#(
	parameter int MAX_SET    = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input words.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // [3:0] entry_index, [35:4] entry_value, rest zero
	input  logic [CMD_W-1:0]  s_tuser,   // [1:0] command
	// Result words.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ELEM_W-1:0] m_tdata,   // [31:0] element
	output logic              m_tlast,
	output logic [2:0]        m_tuser,   // [0] more_follow, [2:1] status
	// Configuration writes.
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

`include "k_combination_enumerator_defines.svh"

	localparam int PW = $clog2(MAX_SET);
	localparam int NW = $clog2(MAX_SET + 1);

	logic [CFG_W-1:0]      set_size_q, subset_size_q;
	logic                  output_mode_q;
	logic [NW-1:0]         n_eff, k_eff;

	logic [ENTRY_W-1:0]    entry_index;
	logic signed [ELEM_W-1:0] entry_value;
	logic                  tbl_we;
	logic [VALUE_BITS-1:0] tbl_wdata, tbl_rdata;
	logic [ELEM_W-1:0]     value_ext;

	logic                  pos_we;
	logic [PW-1:0]         pos_addr, pos_wdata, pos_rdata, elem_pos;
	kce_out_t              out_req;
	logic                  out_taken;

	logic                  m_valid_q;
	logic [ELEM_W-1:0]     elem_q;
	logic                  last_q, more_q;
	logic [STAT_W-1:0]     status_q;

	assign entry_index = s_tdata[3:0];
	assign entry_value = s_tdata[35:4];

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q    <= CFG_W'(16);
			subset_size_q <= CFG_W'(1);
			output_mode_q <= MODE_VALUE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_SIZE:    set_size_q    <= cfg_data;
				REG_SUBSET_SIZE: subset_size_q <= cfg_data;
				REG_OUTPUT_MODE: output_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp n to 1..MAX_SET and k to 1..n.
	always_comb begin
		if (set_size_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(set_size_q) > MAX_SET) begin
			n_eff = NW'(MAX_SET);
		end else begin
			n_eff = NW'(set_size_q);
		end
		if (subset_size_q == '0) begin
			k_eff = NW'(1);
		end else if (32'(subset_size_q) > 32'(n_eff)) begin
			k_eff = n_eff;
		end else begin
			k_eff = NW'(subset_size_q);
		end
	end

	// Value width conversion on the way into and out of the set table.
	generate
		if (VALUE_BITS >= ELEM_W) begin : g_wide
			assign tbl_wdata = VALUE_BITS'(entry_value);
			assign value_ext = tbl_rdata[ELEM_W-1:0];
		end else begin : g_narrow
			assign tbl_wdata = entry_value[VALUE_BITS-1:0];
			assign value_ext = {{(ELEM_W-VALUE_BITS){tbl_rdata[VALUE_BITS-1]}}, tbl_rdata};
		end
	endgenerate

	// Loads go straight into the set table; slots past the table are ignored.
	assign tbl_we = s_tvalid && s_tready && (s_tuser == CMD_LOAD)
		&& (32'(entry_index) < MAX_SET);

	kce_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_SET)
	) u_set_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (PW'(entry_index)),
		.wdata (tbl_wdata),
		.raddr (pos_rdata),
		.rdata (tbl_rdata)
	);

	kce_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_SET)
	) u_positions (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_addr),
		.wdata (pos_wdata),
		.raddr (pos_addr),
		.rdata (pos_rdata)
	);

	kce_ctrl #(
		.MAX_SET (MAX_SET)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.cmd       (s_tuser),
		.ready     (s_tready),
		.n_eff     (n_eff),
		.k_eff     (k_eff),
		.pos_rdata (pos_rdata),
		.pos_we    (pos_we),
		.pos_addr  (pos_addr),
		.pos_wdata (pos_wdata),
		.elem_pos  (elem_pos),
		.out_taken (out_taken),
		.out_req   (out_req)
	);

	// Output word register.
	assign out_taken = m_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_req.load) begin
			m_valid_q <= 1'b1;
		end else if (out_taken) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_req.load) begin
			if (out_req.status != STAT_OK) begin
				elem_q <= '0;
			end else if (output_mode_q == MODE_VALUE) begin
				elem_q <= value_ext;
			end else begin
				elem_q <= ELEM_W'(elem_pos);
			end
			last_q   <= out_req.last;
			more_q   <= out_req.more;
			status_q <= out_req.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = elem_q;
	assign m_tlast  = last_q;
	assign m_tuser  = {status_q, more_q};

	// The sequencer never takes a new command while a word is pending.
	`KCE_ASSERT_NOW(a_busy_not_ready, m_tvalid, !s_tready, "input ready while a word is pending")
	// A status word is a lone, empty, final word.
	`KCE_ASSERT_NOW(a_status_word, m_tvalid && m_tuser[2:1] != STAT_OK, m_tlast && !m_tuser[0] && m_tdata == '0, "malformed status word")
	// Once the final word of a run is taken, the block is idle again.
	`KCE_ASSERT_NEXT(a_run_end_idle, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "not idle after end of run")

endmodule
